FILE: design/eida_pkg.sv
// Shared definitions for the entity ID allocator: field widths, stream packing,
// operation and status codes, and the controller state type.
// No dependencies.
`default_nettype none

package eida_pkg;

    localparam int unsigned DEF_ENTITY_CAPACITY = 256;
    localparam int unsigned DEF_COMPONENT_BITS  = 64;

    // Payload field widths.
    localparam int unsigned FUNC_W      = 3;
    localparam int unsigned ID_FIELD_W  = 8;
    localparam int unsigned COMP_W      = 6;
    localparam int unsigned MASK_W      = 64;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned COUNT_W     = 9;

    // Stream data widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned M_TDATA_W = 24;

    // Input field offsets inside s_tdata.
    localparam int unsigned FUNC_LSB = 0;
    localparam int unsigned ID_LSB   = FUNC_LSB + FUNC_W;
    localparam int unsigned COMP_LSB = ID_LSB + ID_FIELD_W;
    localparam int unsigned MASK_LSB = COMP_LSB + COMP_W;

    // Unused upper bits of m_tdata.
    localparam int unsigned OUT_PAD_W = M_TDATA_W - (ID_FIELD_W + STATUS_W + 1 + COUNT_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE  = 3'd0,
        FN_DESTROY = 3'd1,
        FN_SET     = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_TEST    = 3'd4,
        FN_MATCH   = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DST_LINK,
        ST_DST_FREE
    } state_t;

endpackage

`default_nettype wire

FILE: design/entity_id_allocator_with_signatures.sv
// Entity ID allocator with per-entity component signatures, top level.
// Depends on eida_pkg for field widths, operation codes and the state type.
// After reset the block clears every entry of its entity memory and accepts no
// transfer until that pass is done. Each operation is then accepted with a
// memory read in ST_IDLE and executed in ST_EXEC; destroy goes on through
// ST_DST_LINK and ST_DST_FREE: the slot of the destroyed entity and the last
// dense entry are read first, then the moved entity's slot is read back and
// rewritten, and finally the destroyed entry is cleared. Each memory has one
// read and one write port, and that chain of dependent accesses is why destroy
// needs the extra states. A result waits in an output register; the block holds
// the finishing step while a previous result has not been taken. State lives in
// two memories: the entity memory (live flag, dense slot, signature) and the
// list memory: dense list from the bottom up, free ID stack from the top down.
`default_nettype none

module entity_id_allocator_with_signatures
    import eida_pkg::*;
#(
    parameter int unsigned ENTITY_CAPACITY = DEF_ENTITY_CAPACITY,
    parameter int unsigned COMPONENT_BITS  = DEF_COMPONENT_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // func[2:0], entity_id[10:3], component[16:11], required_mask[80:17]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // result_id[7:0], status[9:8], hit[10], live_count[19:11]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned ID_W  = $clog2(ENTITY_CAPACITY);
    localparam int unsigned CNT_W = $clog2(ENTITY_CAPACITY + 1);
    localparam int unsigned SIG_W = COMPONENT_BITS;

    typedef struct packed {
        logic             live;
        logic [ID_W-1:0]  slot;
        logic [SIG_W-1:0] sig;
    } entry_t;

    // Memories.
    entry_t          ent_mem  [ENTITY_CAPACITY];
    logic [ID_W-1:0] list_mem [ENTITY_CAPACITY];

    entry_t          ent_rd_reg;
    logic [ID_W-1:0] list_rd_reg;

    logic            ent_we, ent_re, list_we, list_re;
    logic [ID_W-1:0] ent_waddr, ent_raddr, list_waddr, list_raddr, list_wdata;
    entry_t          ent_wdata;

    // Control state.
    state_t           state_reg, state_next;
    logic [ID_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0] fresh_next_reg, fresh_next_next;
    logic [CNT_W-1:0] live_total_reg, live_total_next;
    logic [CNT_W-1:0] free_depth_reg, free_depth_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Captured input item.
    func_t              func_reg;
    logic [ID_FIELD_W-1:0] id_reg;
    logic [COMP_W-1:0]  comp_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [ID_W-1:0]    slot_reg;

    logic                  accept, out_free, clr_last;
    logic                  id_ok, comp_ok, entity_live, destroy_go;
    logic [ID_W-1:0]       id_addr, stack_top_addr, push_addr, last_addr, new_id;
    logic [SIG_W-1:0]      comp_bit;
    logic                  load_out;
    logic [ID_FIELD_W-1:0] res_id;
    status_t               res_status;
    logic                  res_hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign clr_last    = (clr_cnt_reg == ID_W'(ENTITY_CAPACITY - 1));
    assign id_ok       = 32'(id_reg) < ENTITY_CAPACITY;
    assign comp_ok     = 32'(comp_reg) < COMPONENT_BITS;
    assign id_addr     = ID_W'(id_reg);
    assign entity_live = id_ok && ent_rd_reg.live;
    assign destroy_go  = (func_reg == FN_DESTROY) && entity_live;
    assign comp_bit    = SIG_W'(1) << comp_reg;

    // The free stack grows downward from the top of the list memory; the
    // dense list and the stack together never hold more than the capacity.
    assign stack_top_addr = ID_W'(CNT_W'(ENTITY_CAPACITY) - free_depth_reg);
    assign push_addr      = ID_W'(CNT_W'(ENTITY_CAPACITY - 1) - free_depth_reg);
    assign last_addr      = ID_W'(live_total_reg - CNT_W'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (destroy_go) begin
                    state_next = ST_DST_LINK;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DST_LINK: state_next = ST_DST_FREE;
            ST_DST_FREE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Memory controls, counters and the result.
    always_comb begin
        ent_we          = 1'b0;
        ent_waddr       = id_addr;
        ent_wdata       = '0;
        ent_re          = 1'b0;
        ent_raddr       = id_addr;
        list_we         = 1'b0;
        list_waddr      = push_addr;
        list_wdata      = list_rd_reg;
        list_re         = 1'b0;
        list_raddr      = last_addr;
        fresh_next_next = fresh_next_reg;
        live_total_next = live_total_reg;
        free_depth_next = free_depth_reg;
        load_out        = 1'b0;
        res_id          = id_reg;
        res_status      = STATUS_OK;
        res_hit         = 1'b0;
        new_id          = list_rd_reg;

        case (state_reg)
            ST_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = clr_cnt_reg;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ent_re    = 1'b1;
                    ent_raddr = ID_W'(s_tdata[ID_LSB +: ID_FIELD_W]);
                    list_re   = 1'b1;
                    if (func_t'(s_tdata[FUNC_LSB +: FUNC_W]) == FN_CREATE) begin
                        list_raddr = stack_top_addr;
                    end else begin
                        list_raddr = last_addr;
                    end
                end
            end
            ST_EXEC: begin
                case (func_reg)
                    FN_CREATE: begin
                        load_out = out_free;
                        if (free_depth_reg != '0) begin
                            new_id          = list_rd_reg;
                            free_depth_next = free_depth_reg - CNT_W'(1);
                        end else begin
                            new_id          = ID_W'(fresh_next_reg);
                            fresh_next_next = fresh_next_reg + CNT_W'(1);
                        end
                        if (free_depth_reg == '0 && fresh_next_reg == CNT_W'(ENTITY_CAPACITY))
                        begin
                            fresh_next_next = fresh_next_reg;
                            res_id          = '0;
                            res_status      = STATUS_FULL;
                        end else begin
                            ent_we          = out_free;
                            ent_waddr       = new_id;
                            ent_wdata.live  = 1'b1;
                            ent_wdata.slot  = ID_W'(live_total_reg);
                            list_we         = out_free;
                            list_waddr      = ID_W'(live_total_reg);
                            list_wdata      = new_id;
                            live_total_next = live_total_reg + CNT_W'(1);
                            res_id          = ID_FIELD_W'(new_id);
                        end
                        if (!out_free) begin
                            fresh_next_next = fresh_next_reg;
                            free_depth_next = free_depth_reg;
                            live_total_next = live_total_reg;
                        end
                    end
                    FN_DESTROY: begin
                        if (entity_live) begin
                            // Move the last dense entry into the freed slot and
                            // fetch its entity record for the slot update.
                            list_we    = 1'b1;
                            list_waddr = ent_rd_reg.slot;
                            list_wdata = list_rd_reg;
                            ent_re     = 1'b1;
                            ent_raddr  = list_rd_reg;
                        end else begin
                            load_out   = out_free;
                            res_status = STATUS_INVALID;
                        end
                    end
                    FN_SET, FN_CLEAR, FN_TEST: begin
                        load_out = out_free;
                        if (!entity_live || !comp_ok) begin
                            res_status = STATUS_INVALID;
                        end else if (func_reg == FN_TEST) begin
                            res_hit = |(ent_rd_reg.sig & comp_bit);
                        end else begin
                            ent_we    = out_free;
                            ent_wdata = ent_rd_reg;
                            if (func_reg == FN_SET) begin
                                ent_wdata.sig = ent_rd_reg.sig | comp_bit;
                            end else begin
                                ent_wdata.sig = ent_rd_reg.sig & ~comp_bit;
                            end
                        end
                    end
                    FN_MATCH: begin
                        load_out = out_free;
                        if (!entity_live) begin
                            res_status = STATUS_INVALID;
                        end else begin
                            res_hit = ((MASK_W'(ent_rd_reg.sig) & mask_reg) == mask_reg);
                        end
                    end
                    default: begin
                        load_out   = out_free;
                        res_status = STATUS_INVALID;
                    end
                endcase
            end
            ST_DST_LINK: begin
                // The moved entity keeps its flag and signature, takes the slot.
                ent_we         = 1'b1;
                ent_waddr      = list_rd_reg;
                ent_wdata      = ent_rd_reg;
                ent_wdata.slot = slot_reg;
                list_we        = 1'b1;
                list_waddr     = push_addr;
                list_wdata     = id_addr;
            end
            ST_DST_FREE: begin
                // Written last, so destroying the last dense entry still ends dead.
                ent_we    = out_free;
                ent_waddr = id_addr;
                load_out  = out_free;
                if (out_free) begin
                    live_total_next = live_total_reg - CNT_W'(1);
                    free_depth_next = free_depth_reg + CNT_W'(1);
                end
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign m_tvalid_next = load_out ? 1'b1 : (m_tvalid_reg && !m_tready);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            fresh_next_reg <= '0;
            live_total_reg <= '0;
            free_depth_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fresh_next_reg <= fresh_next_next;
            live_total_reg <= live_total_next;
            free_depth_reg <= free_depth_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + ID_W'(1);
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_t'(s_tdata[FUNC_LSB +: FUNC_W]);
            id_reg   <= s_tdata[ID_LSB +: ID_FIELD_W];
            comp_reg <= s_tdata[COMP_LSB +: COMP_W];
            mask_reg <= s_tdata[MASK_LSB +: MASK_W];
        end
        if (state_reg == ST_EXEC) slot_reg <= ent_rd_reg.slot;
        if (load_out) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, COUNT_W'(live_total_next), res_hit,
                            res_status, res_id};
        end
    end

    // Entity memory.
    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        if (ent_re) ent_rd_reg <= ent_mem[ent_raddr];
    end

    // List memory: dense list at the bottom, free stack at the top.
    always_ff @(posedge aclk) begin
        if (list_we) list_mem[list_waddr] <= list_wdata;
        if (list_re) list_rd_reg <= list_mem[list_raddr];
    end

    // Live and free entities never outnumber the IDs handed out so far.
    a_id_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (({1'b0, live_total_reg} + {1'b0, free_depth_reg}) <= {1'b0, fresh_next_reg}))
        else $error("live plus free IDs exceed IDs handed out");

    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, fresh_next_reg} <= (CNT_W + 1)'(ENTITY_CAPACITY)))
        else $error("fresh ID counter beyond capacity");

    a_create_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && state_reg == ST_EXEC && func_reg == FN_CREATE
            && res_status == STATUS_OK)
        |=> (live_total_reg == $past(live_total_reg) + CNT_W'(1)))
        else $error("successful create did not add one live entity");

    a_destroy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && state_reg == ST_DST_FREE)
        |=> (live_total_reg == $past(live_total_reg) - CNT_W'(1))
            && (free_depth_reg == $past(free_depth_reg) + CNT_W'(1)))
        else $error("destroy did not move one ID to the free stack");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!list_we && !list_re && !ent_re && !load_out))
        else $error("memory access other than clearing during the clearing pass");

endmodule

`default_nettype wire
